FILE: design/ehdf_pkg.sv
`default_nettype none

package ehdf_pkg;

	// Number of joints served by the block.
	localparam int JOINTS = 12;
	// Address width of the per-joint position store.
	localparam int JOINT_AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// Field widths.
	localparam int JIDX_W = 4;
	localparam int POS_W = 20;
	localparam int VEL_W = 16;
	localparam int DT_W = 16;
	localparam int THR_W = 15;
	localparam int ALPHA_W = 17;
	localparam int TMO_W = 24;
	localparam int TIME_W = 25;
	localparam int SUM_W = 34;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	// Commands.
	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// Drive modes.
	localparam logic MODE_HOLD = 1'b0;
	localparam logic MODE_LOCK = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ALPHA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [THR_W-1:0] THR_RESET = 15'd512;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd328;
	localparam logic [TMO_W-1:0] TMO_RESET = 24'd1500000;

	// Alpha of exactly one in Q1.16.
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

	typedef struct packed {
		logic command;
		logic [JIDX_W-1:0] joint_index;
		logic signed [POS_W-1:0] joint_position;
		logic signed [VEL_W-1:0] joint_velocity;
		logic [DT_W-1:0] tick_dt_us;
	} sample_t;

	typedef struct packed {
		logic [JIDX_W-1:0] out_joint;
		logic drive_mode;
		logic signed [POS_W-1:0] position_command;
		logic last_of_run;
	} result_t;

endpackage

`default_nettype wire

FILE: design/ehdf_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ehdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/emergency_hold_damp_then_freeze.sv
`default_nettype none

// An advance word passes the states ADV_MUL, where the read data of the position store is used
// and the alpha product is registered, and ADV_EMIT, which loads its result word. An init
// word on the last joint passes INIT, DECIDE and REPLAY, which loads its twelve results in turn;
// other init words pass INIT only. A new word is taken only once the sequencer is idle again,
// so output stalls also hold the input. Reset clears mode, timer, speed sum, store valid bits
// and configuration to their defaults; no clearing pass is needed.
module emergency_hold_damp_then_freeze (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire ehdf_pkg::sample_t sample,
	output logic result_valid,
	input wire logic result_stall,
	output ehdf_pkg::result_t result,
	input wire logic cfg_we,
	input wire logic [ehdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [ehdf_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_REPLAY = 3'd3;
	localparam logic [2:0] ST_ADV_MUL = 3'd4;
	localparam logic [2:0] ST_ADV_EMIT = 3'd5;

	localparam int AW = ehdf_pkg::JOINT_AW;
	localparam int PW = ehdf_pkg::POS_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(ehdf_pkg::JOINTS - 1);
	localparam logic [ehdf_pkg::JIDX_W-1:0] LAST_JOINT =
		ehdf_pkg::JIDX_W'(ehdf_pkg::JOINTS - 1);
	localparam logic [ehdf_pkg::SUM_W-1:0] SUM_MAX = '1;
	localparam logic [ehdf_pkg::TIME_W-1:0] TIME_MAX = '1;

	// Configuration registers.
	logic [ehdf_pkg::THR_W-1:0] thr_q;
	logic [ehdf_pkg::ALPHA_W-1:0] alpha_q;
	logic [ehdf_pkg::TMO_W-1:0] tmo_q;

	// Block state.
	logic moving_q;
	logic [ehdf_pkg::TIME_W-1:0] time_q;
	logic [ehdf_pkg::SUM_W-1:0] sum_q;
	logic [ehdf_pkg::JOINTS-1:0] valid_q;

	// Sequencer.
	logic [2:0] state_q;
	logic [AW-1:0] cnt_q;
	ehdf_pkg::sample_t item_q;
	logic signed [PW-1:0] prev_q;
	logic signed [38:0] prod_q;
	logic rvalid_q;

	// Output register.
	logic result_valid_q;
	ehdf_pkg::result_t result_q;

	// Position store ports.
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [PW-1:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [PW-1:0] ram_rdata;

	logic accept;
	logic in_range;
	logic item_last;
	logic out_free;
	logic out_load;
	logic signed [PW-1:0] prev_eff;
	logic signed [2*ehdf_pkg::VEL_W-1:0] vel_sq;
	logic [ehdf_pkg::SUM_W:0] sum_add;
	logic [ehdf_pkg::SUM_W-1:0] sum_nx;
	logic [2*ehdf_pkg::THR_W-1:0] thr_sq;
	logic [ehdf_pkg::ALPHA_W-1:0] alpha_sat;
	logic signed [PW:0] diff;
	logic signed [38:0] prod_d;
	logic signed [PW-1:0] damp_pos;
	logic [ehdf_pkg::TIME_W:0] time_add;
	logic [ehdf_pkg::TIME_W-1:0] time_nx;
	logic time_hit;

	ehdf_ram #(
		.WIDTH(PW),
		.DEPTH(ehdf_pkg::JOINTS)
	) u_prev_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Words are taken only while the sequencer is idle; a finished result may still
	// wait in the output register at that time.
	assign sample_stall = (state_q != ST_IDLE);
	assign accept = sample_valid && !sample_stall;
	assign in_range = (32'(sample.joint_index) < ehdf_pkg::JOINTS);
	assign item_last = (item_q.joint_index == LAST_JOINT);
	assign out_free = !result_valid_q || !result_stall;
	// A result word is loaded into the output register in this cycle.
	assign out_load = out_free && ((state_q == ST_REPLAY) || (state_q == ST_ADV_EMIT));

	assign result_valid = result_valid_q;
	assign result = result_q;

	// A store entry that was never written reads as zero.
	assign prev_eff = rvalid_q ? $signed(ram_rdata) : '0;

	// Squared speed accumulation, saturating.
	assign vel_sq = item_q.joint_velocity * item_q.joint_velocity;
	assign sum_add = {1'b0, sum_q} + (ehdf_pkg::SUM_W + 1)'($unsigned(vel_sq));
	assign sum_nx = sum_add[ehdf_pkg::SUM_W] ? SUM_MAX : sum_add[ehdf_pkg::SUM_W-1:0];
	assign thr_sq = thr_q * thr_q;

	// Smoothing: alpha is clamped to one, the product is floored by the shift.
	assign alpha_sat = (alpha_q > ehdf_pkg::ALPHA_ONE) ? ehdf_pkg::ALPHA_ONE : alpha_q;
	assign diff = {item_q.joint_position[PW-1], item_q.joint_position} -
		{prev_eff[PW-1], prev_eff};
	assign prod_d = $signed({1'b0, alpha_sat}) * diff;
	assign damp_pos = prev_q + $signed(prod_q[PW+15:16]);

	// Damping timer, saturating, and the timeout check on its new value.
	assign time_add = {1'b0, time_q} + (ehdf_pkg::TIME_W + 1)'(item_q.tick_dt_us);
	assign time_nx = time_add[ehdf_pkg::TIME_W] ? TIME_MAX : time_add[ehdf_pkg::TIME_W-1:0];
	assign time_hit = (time_nx >= ehdf_pkg::TIME_W'(tmo_q));

	// Store access: writes and reads never address the same entry in overlapping
	// cycles, since the sequencer handles one word at a time.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(item_q.joint_index);
		ram_wdata = item_q.joint_position;
		ram_re = 1'b0;
		ram_raddr = AW'(sample.joint_index);
		unique case (state_q)
			ST_IDLE: begin
				ram_re = accept && in_range;
			end
			ST_INIT: begin
				ram_we = 1'b1;
			end
			ST_DECIDE: begin
				ram_re = 1'b1;
				ram_raddr = '0;
			end
			ST_REPLAY: begin
				ram_re = out_free && (cnt_q != LAST_ADDR);
				ram_raddr = cnt_q + AW'(1);
			end
			ST_ADV_MUL: begin
			end
			ST_ADV_EMIT: begin
				ram_we = out_free && moving_q;
				ram_wdata = damp_pos;
			end
			default: begin
			end
		endcase
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ehdf_pkg::THR_RESET;
			alpha_q <= ehdf_pkg::ALPHA_RESET;
			tmo_q <= ehdf_pkg::TMO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ehdf_pkg::REG_VELOCITY_THRESHOLD: thr_q <= cfg_data[ehdf_pkg::THR_W-1:0];
				ehdf_pkg::REG_SMOOTHING_ALPHA: alpha_q <= cfg_data[ehdf_pkg::ALPHA_W-1:0];
				ehdf_pkg::REG_TIMEOUT_US: tmo_q <= cfg_data[ehdf_pkg::TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Data registers that need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= sample;
		end
		if (state_q == ST_ADV_MUL) begin
			prev_q <= prev_eff;
			prod_q <= prod_d;
		end
	end

	// Sequencer, mode, timer, speed sum and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			moving_q <= 1'b0;
			time_q <= '0;
			sum_q <= '0;
			valid_q <= '0;
			rvalid_q <= 1'b0;
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			if (ram_re) begin
				rvalid_q <= valid_q[ram_raddr];
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					// Words for joints beyond the last are dropped here.
					if (accept && in_range) begin
						state_q <= (sample.command == ehdf_pkg::CMD_INIT) ?
							ST_INIT : ST_ADV_MUL;
					end
				end
				ST_INIT: begin
					// The position goes to the store in this cycle.
					if (item_last) begin
						sum_q <= sum_nx;
						state_q <= ST_DECIDE;
					end else begin
						sum_q <= sum_nx;
						state_q <= ST_IDLE;
					end
				end
				ST_DECIDE: begin
					moving_q <= (sum_q > ehdf_pkg::SUM_W'(thr_sq));
					sum_q <= '0;
					time_q <= '0;
					cnt_q <= '0;
					state_q <= ST_REPLAY;
				end
				ST_REPLAY: begin
					// The smoothed position of a freshly stored joint is the stored
					// position itself, so the store is replayed without change.
					if (out_free) begin
						result_q.out_joint <= ehdf_pkg::JIDX_W'(cnt_q);
						result_q.drive_mode <= moving_q ? ehdf_pkg::MODE_HOLD :
							ehdf_pkg::MODE_LOCK;
						result_q.position_command <= moving_q ? prev_eff : '0;
						result_q.last_of_run <= (cnt_q == LAST_ADDR);
						if (cnt_q == LAST_ADDR) begin
							if (moving_q) begin
								time_q <= time_nx;
								if (time_hit) begin
									moving_q <= 1'b0;
								end
							end
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + AW'(1);
						end
					end
				end
				ST_ADV_MUL: begin
					state_q <= ST_ADV_EMIT;
				end
				ST_ADV_EMIT: begin
					if (out_free) begin
						result_q.out_joint <= item_q.joint_index;
						result_q.drive_mode <= moving_q ? ehdf_pkg::MODE_HOLD :
							ehdf_pkg::MODE_LOCK;
						result_q.position_command <= moving_q ? damp_pos : '0;
						result_q.last_of_run <= 1'b1;
						// The switch to freeze shows from the next word on.
						if (item_last && moving_q) begin
							time_q <= time_nx;
							if (time_hit) begin
								moving_q <= 1'b0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
